### sv/kwod_pkg.sv
// shared types, constants and cost helpers for the keyboard weighted osa distance block
`timescale 1ns / 1ps

package kwod_pkg;

  localparam int unsigned MAX_LEN_DEF   = 64;
  localparam int unsigned FRAC_BITS_DEF = 8;

  localparam int unsigned VAL_W   = 16;
  localparam logic [VAL_W-1:0] VAL_MAX = 16'hFFFF;

  // squared key distance: row delta up to 3, column delta up to 9
  localparam int unsigned D2_W = 7;
  localparam int unsigned D2_N = 128;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_ROW    = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  typedef struct packed {
    logic       hit;
    logic [1:0] row;
    logic [3:0] col;
  } key_pos_t;

  // token handed from cell to cell, one cell per cycle unless the row is stalled
  typedef struct packed {
    logic             valid;
    logic             fin;
    logic             tr_ok;
    logic [7:0]       ch;
    logic [7:0]       last_ch;
    logic [7:0]       left_ch;
    logic [VAL_W-1:0] cur_l;
    logic [VAL_W-1:0] diag;
    logic [VAL_W-1:0] pp1;
    logic [VAL_W-1:0] pp2;
    logic [VAL_W-1:0] score;
    logic             ovf;
  } tok_t;

  // ascii upper case to lower case, nothing else folded
  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[8'h41:8'h5A]}) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  function automatic key_pos_t key_pos(input logic [7:0] c);
    key_pos_t k;
    k = '{hit: 1'b1, row: 2'd0, col: 4'd0};
    case (c)
      "1": k.col = 4'd0;
      "2": k.col = 4'd1;
      "3": k.col = 4'd2;
      "4": k.col = 4'd3;
      "5": k.col = 4'd4;
      "6": k.col = 4'd5;
      "7": k.col = 4'd6;
      "8": k.col = 4'd7;
      "9": k.col = 4'd8;
      "0": k.col = 4'd9;
      "q": begin k.row = 2'd1; k.col = 4'd0; end
      "w": begin k.row = 2'd1; k.col = 4'd1; end
      "e": begin k.row = 2'd1; k.col = 4'd2; end
      "r": begin k.row = 2'd1; k.col = 4'd3; end
      "t": begin k.row = 2'd1; k.col = 4'd4; end
      "y": begin k.row = 2'd1; k.col = 4'd5; end
      "u": begin k.row = 2'd1; k.col = 4'd6; end
      "i": begin k.row = 2'd1; k.col = 4'd7; end
      "o": begin k.row = 2'd1; k.col = 4'd8; end
      "p": begin k.row = 2'd1; k.col = 4'd9; end
      "a": begin k.row = 2'd2; k.col = 4'd0; end
      "s": begin k.row = 2'd2; k.col = 4'd1; end
      "d": begin k.row = 2'd2; k.col = 4'd2; end
      "f": begin k.row = 2'd2; k.col = 4'd3; end
      "g": begin k.row = 2'd2; k.col = 4'd4; end
      "h": begin k.row = 2'd2; k.col = 4'd5; end
      "j": begin k.row = 2'd2; k.col = 4'd6; end
      "k": begin k.row = 2'd2; k.col = 4'd7; end
      "l": begin k.row = 2'd2; k.col = 4'd8; end
      "z": begin k.row = 2'd3; k.col = 4'd0; end
      "x": begin k.row = 2'd3; k.col = 4'd1; end
      "c": begin k.row = 2'd3; k.col = 4'd2; end
      "v": begin k.row = 2'd3; k.col = 4'd3; end
      "b": begin k.row = 2'd3; k.col = 4'd4; end
      "n": begin k.row = 2'd3; k.col = 4'd5; end
      "m": begin k.row = 2'd3; k.col = 4'd6; end
      default: k.hit = 1'b0;
    endcase
    return k;
  endfunction

  // half the key distance, rounded, with frac fraction bits; elaboration only
  function automatic int unsigned half_key_dist(input int unsigned d2, input int unsigned frac);
    longint unsigned v;
    longint unsigned r;
    longint unsigned bit_w;
    v = longint'(d2) << (2 * frac - 2);
    r = 0;
    bit_w = 64'd1 << 24;
    while (bit_w != 0) begin
      if ((r + bit_w) * (r + bit_w) <= v) begin
        r = r + bit_w;
      end
      bit_w = bit_w >> 1;
    end
    if (v - r * r > r) begin
      r = r + 1;
    end
    return int'(r);
  endfunction

endpackage

### sv/kwod_cell.sv
// one column cell of the edit distance chain
`timescale 1ns / 1ps

module kwod_cell #(
  parameter int unsigned FRAC_BITS = kwod_pkg::FRAC_BITS_DEF,
  parameter int unsigned IDX       = 0,
  parameter int unsigned CW        = 7
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           advance,
  input  logic           col_wr,
  input  logic [CW-1:0]  col_idx,
  input  logic [7:0]     col_data,
  input  kwod_pkg::tok_t tok_in,
  output kwod_pkg::tok_t tok_out
);

  localparam int unsigned VW    = kwod_pkg::VAL_W;
  localparam int unsigned CST_W = FRAC_BITS + 3;
  localparam int unsigned SUM_W = (FRAC_BITS + 4 > 17) ? FRAC_BITS + 5 : 18;
  localparam int unsigned DW    = kwod_pkg::D2_W;

  localparam logic [CST_W-1:0] CST_ONE = CST_W'(1) << FRAC_BITS;
  localparam logic [SUM_W-1:0] SUM_ONE = SUM_W'(1) << FRAC_BITS;
  localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(kwod_pkg::VAL_MAX);

  localparam longint unsigned PREV_RST_W = longint'(IDX + 1) << FRAC_BITS;
  localparam logic [VW-1:0] PREV_RST =
    (PREV_RST_W > 64'hFFFF) ? kwod_pkg::VAL_MAX : VW'(PREV_RST_W);

  localparam logic [CW-1:0] MY_IDX   = CW'(IDX);
  localparam logic [CW-1:0] NEXT_IDX = CW'(IDX + 1);
  localparam bit HAS_LEFT = (IDX != 0);

  logic [CST_W-1:0] cost_tbl [kwod_pkg::D2_N];

  genvar d;
  generate
    for (d = 0; d < kwod_pkg::D2_N; d++) begin : g_tbl
      localparam logic [CST_W-1:0] C = CST_W'(kwod_pkg::half_key_dist(d, FRAC_BITS));
      assign cost_tbl[d] = C;
    end
  endgenerate

  logic [7:0]    col_ch_r;
  logic          tail_r;
  logic [VW-1:0] prev_r;
  logic [VW-1:0] pprev_r;
  kwod_pkg::tok_t tok_r;
  kwod_pkg::tok_t tok_nxt;

  logic [7:0]       fx;
  logic [7:0]       fy;
  kwod_pkg::key_pos_t kx;
  kwod_pkg::key_pos_t ky;
  logic [1:0]       dr;
  logic [3:0]       dc;
  logic [DW-1:0]    d2;
  logic [CST_W-1:0] cost;
  logic [SUM_W-1:0] t_up;
  logic [SUM_W-1:0] t_left;
  logic [SUM_W-1:0] t_diag;
  logic [SUM_W-1:0] t_tr;
  logic             tr_hit;
  logic [SUM_W-1:0] best;
  logic [VW-1:0]    cur;

  always_comb begin
    fx = kwod_pkg::fold(tok_in.ch);
    fy = kwod_pkg::fold(col_ch_r);
    kx = kwod_pkg::key_pos(fx);
    ky = kwod_pkg::key_pos(fy);
    dr = (kx.row >= ky.row) ? kx.row - ky.row : ky.row - kx.row;
    dc = (kx.col >= ky.col) ? kx.col - ky.col : ky.col - kx.col;
    d2 = DW'(DW'(dr) * DW'(dr)) + DW'(DW'(dc) * DW'(dc));
    if (fx == fy) begin
      cost = '0;
    end else if (!kx.hit || !ky.hit) begin
      cost = CST_ONE;
    end else begin
      cost = cost_tbl[d2];
    end

    t_up   = SUM_W'(prev_r) + SUM_ONE;
    t_left = SUM_W'(tok_in.cur_l) + SUM_ONE;
    t_diag = SUM_W'(tok_in.diag) + SUM_W'(cost);
    t_tr   = SUM_W'(tok_in.pp2) + SUM_ONE;
    tr_hit = HAS_LEFT && tok_in.tr_ok && (tok_in.ch == tok_in.left_ch) &&
             (tok_in.last_ch == col_ch_r);

    best = t_up;
    if (t_left < best) begin
      best = t_left;
    end
    if (t_diag < best) begin
      best = t_diag;
    end
    if (tr_hit && (t_tr < best)) begin
      best = t_tr;
    end
    cur = (best > SUM_MAX) ? kwod_pkg::VAL_MAX : best[VW-1:0];

    tok_nxt = tok_in;
    if (tok_in.valid && !tok_in.fin) begin
      tok_nxt.cur_l   = cur;
      tok_nxt.diag    = prev_r;
      tok_nxt.pp1     = pprev_r;
      tok_nxt.pp2     = tok_in.pp1;
      tok_nxt.left_ch = col_ch_r;
    end
    if (tok_in.valid && tok_in.fin && tail_r) begin
      tok_nxt.score = prev_r;
    end
  end

  always_ff @(posedge clk) begin
    if (col_wr && (col_idx == MY_IDX)) begin
      col_ch_r <= col_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_r  <= 1'b0;
      prev_r  <= PREV_RST;
      pprev_r <= '0;
      tok_r   <= '0;
    end else begin
      // newest column marks itself as the end of the second string
      if (col_wr && (col_idx == MY_IDX)) begin
        tail_r <= 1'b1;
      end else if (advance && tok_in.valid && tok_in.fin) begin
        tail_r <= 1'b0;
      end else if (col_wr && (col_idx == NEXT_IDX)) begin
        tail_r <= 1'b0;
      end
      if (advance && tok_in.valid) begin
        if (tok_in.fin) begin
          prev_r  <= PREV_RST;
          pprev_r <= '0;
        end else begin
          prev_r  <= cur;
          pprev_r <= prev_r;
        end
      end
      if (advance) begin
        tok_r <= tok_nxt;
      end
    end
  end

  assign tok_out = tok_r;

endmodule

### sv/keyboard_weighted_osa_distance_top.sv
// top level of the keyboard weighted osa distance block
`timescale 1ns / 1ps

// Keyboard weighted optimal string alignment distance. Send the second string
// as append transactions, then the first string as row transactions, then a
// finish transaction; the finish produces one result transaction with the
// distance (FRAC_BITS fraction bits) and a flag for truncated strings, and
// clears the string pair. Internally a row of MAX_LEN cells holds one column
// of the table each; every row byte travels down the row one cell per cycle,
// so a new transaction of any kind is taken every cycle unless stalled. A
// finish result passes the head register, every cell of the row and the output
// register. Input is stalled only while a result is held on a stalled output
// and a second finish has reached the end of the row. No clearing pass is
// needed after reset. The user must write transpose enable through the cfg
// port only while no transaction is in flight; the block does not enforce it.
module keyboard_weighted_osa_distance_top #(
  parameter int unsigned MAX_LEN   = kwod_pkg::MAX_LEN_DEF,
  parameter int unsigned FRAC_BITS = kwod_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input transactions
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_ch,
  // result transactions
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_distance,
  output logic        out_too_long,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  localparam int unsigned VW = kwod_pkg::VAL_W;
  localparam logic [CW-1:0] LEN_LIM = CW'(MAX_LEN);

  // string counts and per pair bookkeeping
  logic          tr_en_r;
  logic [CW-1:0] col_cnt_r;
  logic [CW-1:0] col_cnt_nxt;
  logic [CW-1:0] row_cnt_r;
  logic [CW-1:0] row_cnt_nxt;
  logic [7:0]    last_ch_r;
  logic [7:0]    last_ch_nxt;
  logic          ovf_r;
  logic          ovf_nxt;

  kwod_pkg::tok_t head_r;
  kwod_pkg::tok_t head_nxt;
  kwod_pkg::tok_t chain [MAX_LEN + 1];

  logic          advance;
  logic          accept;
  logic          col_wr;
  logic          tail_fin;

  logic          out_valid_r;
  logic [VW-1:0] out_dist_r;
  logic          out_tl_r;

  // count scaled to a table value, saturated to 16 bits
  function automatic logic [VW-1:0] scaled(input logic [CW-1:0] cnt);
    logic [31:0] w;
    w = 32'(cnt) << FRAC_BITS;
    return (w > 32'hFFFF) ? kwod_pkg::VAL_MAX : w[VW-1:0];
  endfunction

  // the row only freezes when a second finished result has nowhere to go
  assign tail_fin = chain[MAX_LEN].valid && chain[MAX_LEN].fin;
  assign advance  = !(out_valid_r && out_stall && tail_fin);
  assign in_stall = !advance;
  assign accept   = in_valid && advance;

  assign cfg_ready = 1'b1;

  always_comb begin
    head_nxt       = head_r;
    head_nxt.valid = 1'b0;
    col_cnt_nxt    = col_cnt_r;
    row_cnt_nxt    = row_cnt_r;
    last_ch_nxt    = last_ch_r;
    ovf_nxt        = ovf_r;
    col_wr         = 1'b0;
    if (accept) begin
      case (in_cmd)
        kwod_pkg::CMD_APPEND: begin
          // appends after the first row byte are dropped silently
          if (row_cnt_r == '0) begin
            if (col_cnt_r < LEN_LIM) begin
              col_wr      = 1'b1;
              col_cnt_nxt = col_cnt_r + CW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
        end
        kwod_pkg::CMD_ROW: begin
          if (row_cnt_r < LEN_LIM) begin
            // column zero of the table lives here, not in a cell
            head_nxt.valid   = 1'b1;
            head_nxt.fin     = 1'b0;
            head_nxt.tr_ok   = tr_en_r && (row_cnt_r != '0);
            head_nxt.ch      = in_ch;
            head_nxt.last_ch = last_ch_r;
            head_nxt.left_ch = '0;
            head_nxt.cur_l   = scaled(row_cnt_r + CW'(1));
            head_nxt.diag    = scaled(row_cnt_r);
            head_nxt.pp1     = (row_cnt_r != '0) ? scaled(row_cnt_r - CW'(1)) : '0;
            head_nxt.pp2     = '0;
            head_nxt.score   = '0;
            head_nxt.ovf     = 1'b0;
            row_cnt_nxt      = row_cnt_r + CW'(1);
            last_ch_nxt      = in_ch;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        kwod_pkg::CMD_FINISH: begin
          // empty second string reports the row count; the tail cell overrides
          head_nxt.valid = 1'b1;
          head_nxt.fin   = 1'b1;
          head_nxt.score = scaled(row_cnt_r);
          head_nxt.ovf   = ovf_r;
          col_cnt_nxt    = '0;
          row_cnt_nxt    = '0;
          last_ch_nxt    = '0;
          ovf_nxt        = 1'b0;
        end
        default: begin
          // unused command, nothing to do
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tr_en_r   <= 1'b1;
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      last_ch_r <= '0;
      ovf_r     <= 1'b0;
      head_r    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        tr_en_r <= cfg_data;
      end
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
      last_ch_r <= last_ch_nxt;
      ovf_r     <= ovf_nxt;
      if (advance) begin
        head_r <= head_nxt;
      end
    end
  end

  assign chain[0] = head_r;

  // one cell per column of the second string
  genvar k;
  generate
    for (k = 0; k < MAX_LEN; k++) begin : g_cell
      kwod_cell #(
        .FRAC_BITS (FRAC_BITS),
        .IDX       (k),
        .CW        (CW)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .col_wr   (col_wr),
        .col_idx  (col_cnt_r),
        .col_data (in_ch),
        .tok_in   (chain[k]),
        .tok_out  (chain[k + 1])
      );
    end
  endgenerate

  // output register, loaded when a finish token leaves the last cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && tail_fin) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && tail_fin) begin
      out_dist_r <= chain[MAX_LEN].score;
      out_tl_r   <= chain[MAX_LEN].ovf;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_dist_r;
  assign out_too_long = out_tl_r;

endmodule

### sv/kwod_checker.sv
// port level checks for the keyboard weighted osa distance top, with its bind
`timescale 1ns / 1ps

module kwod_checker #(
  parameter int unsigned MAX_LEN   = kwod_pkg::MAX_LEN_DEF,
  parameter int unsigned FRAC_BITS = kwod_pkg::FRAC_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_distance,
  input logic        out_too_long
);

  // no entry can exceed the insert plus delete path over both strings
  localparam longint unsigned BOUND_W = longint'(2 * MAX_LEN) << FRAC_BITS;
  localparam logic [15:0] BOUND = (BOUND_W > 64'hFFFF) ? 16'hFFFF : 16'(BOUND_W);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_distance) && $stable(out_too_long))
    else $error("result changed while stalled");

  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_distance <= BOUND)
    else $error("distance above the two string bound");

  a_too_long_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_too_long))
    else $error("truncation flag unknown on a valid result");

endmodule

bind keyboard_weighted_osa_distance_top kwod_checker #(
  .MAX_LEN   (MAX_LEN),
  .FRAC_BITS (FRAC_BITS)
) u_kwod_checker (.*);

### dv/tb.sv
// self-checking testbench for the keyboard weighted osa distance block
`timescale 1ns / 1ps

module tb;

  localparam int unsigned MAX_LEN   = kwod_pkg::MAX_LEN_DEF;
  localparam int unsigned FRAC_BITS = kwod_pkg::FRAC_BITS_DEF;
  localparam int unsigned COST_ONE  = 1 << FRAC_BITS;
  localparam int unsigned SAT_MAX   = 65535;

  // cmd code the block has no use for
  localparam logic [1:0] CMD_NONE = 2'd3;

  // a finish result passes the head register, the cell row and the output register
  localparam int unsigned LATENCY     = MAX_LEN + 2;
  localparam int unsigned SETTLE      = LATENCY + 16;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT = 500000;

  typedef struct {
    logic [15:0] distance;
    logic        too_long;
  } dist_result_t;

  // ---------------------------------------------------------------------------
  // scoreboard: keeps its own copy of the dp rows and the string pair, and a
  // queue of the distances that finish transactions will report
  // ---------------------------------------------------------------------------
  class osa_dist_scoreboard;
    bit           xpose_en;
    logic [7:0]   col_chars [MAX_LEN];
    int unsigned  n_cols;
    int unsigned  n_rows;
    int unsigned  upper_row [MAX_LEN + 1];
    int unsigned  prev2_row [MAX_LEN + 1];
    logic [7:0]   last_ch;
    bit           ovf_seen;
    bit           on_grid [256];
    int           key_row [256];
    int           key_col [256];
    int unsigned  half_dist [91];
    dist_result_t expected_dists [$];
    int unsigned  errors;

    function new();
      string           grid [4];
      logic [7:0]      c;
      longint unsigned v;
      longint unsigned root;
      longint unsigned step;
      grid = '{"1234567890", "qwertyuiop", "asdfghjkl", "zxcvbnm"};
      for (int i = 0; i < 256; i++) begin
        on_grid[i] = 1'b0;
        key_row[i] = 0;
        key_col[i] = 0;
      end
      for (int r = 0; r < 4; r++) begin
        for (int k = 0; k < grid[r].len(); k++) begin
          c = grid[r][k];
          on_grid[c] = 1'b1;
          key_row[c] = r;
          key_col[c] = k;
        end
      end
      // half key distance = sqrt(d2 << (2F - 2)), rounded to nearest
      for (int d2 = 0; d2 <= 90; d2++) begin
        v = longint'(d2) << (2 * FRAC_BITS - 2);
        root = 0;
        for (int b = 20; b >= 0; b--) begin
          step = root + (64'd1 << b);
          if (step * step <= v) begin
            root = step;
          end
        end
        if (v - root * root > root) begin
          root = root + 1;
        end
        half_dist[d2] = int'(root);
      end
      xpose_en = 1'b1;
      errors = 0;
      clear_pair();
    endfunction

    function void clear_pair();
      n_cols = 0;
      n_rows = 0;
      last_ch = 8'd0;
      ovf_seen = 1'b0;
      for (int j = 0; j <= MAX_LEN; j++) begin
        upper_row[j] = sat16(j << FRAC_BITS);
        prev2_row[j] = 0;
      end
    endfunction

    function int unsigned sat16(int unsigned v);
      return (v > SAT_MAX) ? SAT_MAX : v;
    endfunction

    function logic [7:0] fold_case(logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function int unsigned key_sub_cost(logic [7:0] a, logic [7:0] b);
      logic [7:0] x;
      logic [7:0] y;
      int         dr;
      int         dc;
      x = fold_case(a);
      y = fold_case(b);
      if (x == y) begin
        return 0;
      end
      if (!on_grid[x] || !on_grid[y]) begin
        return COST_ONE;
      end
      dr = key_row[x] - key_row[y];
      dc = key_col[x] - key_col[y];
      return half_dist[dr * dr + dc * dc];
    endfunction

    function void set_transpose(bit v);
      xpose_en = v;
    endfunction

    function int unsigned pending();
      return expected_dists.size();
    endfunction

    // advance the model by one accepted input transaction
    function void note_txn(logic [1:0] cmd, logic [7:0] ch);
      int unsigned  cur [MAX_LEN + 1];
      int unsigned  row_idx;
      int unsigned  best;
      int unsigned  t;
      dist_result_t res;
      case (cmd)
        kwod_pkg::CMD_APPEND: begin
          // appends after the first row are dropped silently
          if (n_rows == 0) begin
            if (n_cols >= MAX_LEN) begin
              ovf_seen = 1'b1;
            end else begin
              col_chars[n_cols] = ch;
              n_cols++;
            end
          end
        end
        kwod_pkg::CMD_ROW: begin
          if (n_rows >= MAX_LEN) begin
            ovf_seen = 1'b1;
          end else begin
            row_idx = n_rows + 1;
            cur[0] = sat16(row_idx << FRAC_BITS);
            for (int j = 1; j <= n_cols; j++) begin
              best = upper_row[j] + COST_ONE;
              t = cur[j - 1] + COST_ONE;
              if (t < best) best = t;
              t = upper_row[j - 1] + key_sub_cost(ch, col_chars[j - 1]);
              if (t < best) best = t;
              if (xpose_en && row_idx > 1 && j > 1 && ch == col_chars[j - 2] &&
                  last_ch == col_chars[j - 1]) begin
                t = prev2_row[j - 2] + COST_ONE;
                if (t < best) best = t;
              end
              cur[j] = sat16(best);
            end
            prev2_row = upper_row;
            for (int j = 0; j <= n_cols; j++) begin
              upper_row[j] = cur[j];
            end
            last_ch = ch;
            n_rows = row_idx;
          end
        end
        kwod_pkg::CMD_FINISH: begin
          res.distance = upper_row[n_cols][15:0];
          res.too_long = ovf_seen;
          expected_dists.push_back(res);
          clear_pair();
        end
        default: begin
        end
      endcase
    endfunction

    function void check_result(logic [15:0] distance, logic too_long);
      dist_result_t exp_res;
      if (expected_dists.size() == 0) begin
        $error("unexpected result: distance %0d too_long %0d", distance, too_long);
        errors++;
        return;
      end
      exp_res = expected_dists.pop_front();
      if (distance !== exp_res.distance) begin
        $error("distance mismatch: expected %0d, actual %0d", exp_res.distance, distance);
        errors++;
      end
      if (too_long !== exp_res.too_long) begin
        $error("too_long mismatch: expected %0d, actual %0d", exp_res.too_long, too_long);
        errors++;
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // block under test
  // ---------------------------------------------------------------------------
  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_cmd;
  logic [7:0]  in_ch;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_distance;
  logic        out_too_long;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;

  keyboard_weighted_osa_distance_top u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_ch        (in_ch),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_distance (out_distance),
    .out_too_long (out_too_long),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  osa_dist_scoreboard sb = new();

  // idle percentages for each side, changed by the main sequence
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  // set by the main sequence to ask the receiver for a long hold-off
  bit          hold_req;
  int unsigned items_sent;
  int unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit, far above the slowest legal run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL keyboard_weighted_osa_distance_top");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side: check every accepted transaction, then pick the next stall
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      // values seen here are the ones from before the edge
      if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
        sb.check_result(out_distance, out_too_long);
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        // long hold-off so that results back up and the input stalls
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // one input transaction; valid stays high afterwards, so the caller either
  // sends again at once or lowers it through the idle loop or drain
  task automatic send_item(logic [1:0] cmd, logic [7:0] ch);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_ch <= ch;
    do begin
      @(posedge clk);
    end while (in_stall !== 1'b0);
    sb.note_txn(cmd, ch);
    if (cmd != CMD_NONE) begin
      items_sent++;
    end
  endtask

  // stop sending, wait for every result, then let the cell row empty
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_transpose(bit v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do begin
      @(posedge clk);
    end while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    sb.set_transpose(v);
  endtask

  // character mix: keys on the grid, upper case, a tiny alphabet that makes
  // repeats and swaps likely, and any byte at all
  function automatic logic [7:0] pick_char();
    string       grid_keys;
    int unsigned r;
    grid_keys = "1234567890qwertyuiopasdfghjklzxcvbnm";
    r = $urandom_range(0, 99);
    if (r < 40) return grid_keys[$urandom_range(0, 35)];
    if (r < 55) return 8'($urandom_range(8'h41, 8'h5A));
    if (r < 70) return ($urandom_range(0, 1) != 0) ? "a" : "s";
    if (r < 85) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(128, 255));
  endfunction

  // mostly short strings, now and then past MAX_LEN
  function automatic int unsigned pick_len();
    if ($urandom_range(0, 99) < 8) return $urandom_range(MAX_LEN - 8, MAX_LEN + 6);
    return $urandom_range(0, 8);
  endfunction

  function automatic bit fold_is_letter(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  // one string pair: appends, rows, finish; the rows are often an edited copy
  // of the columns (swaps, substitutions, case flips) so transpositions occur
  task automatic send_pair();
    logic [7:0]  cols [$];
    logic [7:0]  rows [$];
    logic [7:0]  tmp;
    int unsigned n;
    int unsigned r;
    n = pick_len();
    for (int k = 0; k < n; k++) begin
      cols.push_back(pick_char());
    end
    if ($urandom_range(0, 99) < 60) begin
      rows = cols;
      for (int k = 0; k < rows.size(); k++) begin
        r = $urandom_range(0, 99);
        if (r < 15 && k + 1 < rows.size()) begin
          tmp = rows[k];
          rows[k] = rows[k + 1];
          rows[k + 1] = tmp;
          k++;
        end else if (r < 25) begin
          rows[k] = pick_char();
        end else if (r < 30 && fold_is_letter(rows[k])) begin
          rows[k] = rows[k] ^ 8'h20;
        end
      end
    end else begin
      n = pick_len();
      for (int k = 0; k < n; k++) begin
        rows.push_back(pick_char());
      end
    end
    foreach (cols[k]) begin
      send_item(kwod_pkg::CMD_APPEND, cols[k]);
    end
    foreach (rows[k]) begin
      r = $urandom_range(0, 99);
      // noise: unused command, or an append that arrives too late
      if (r < 3) begin
        send_item(CMD_NONE, 8'($urandom_range(0, 255)));
      end else if (r < 6) begin
        send_item(kwod_pkg::CMD_APPEND, pick_char());
      end
      send_item(kwod_pkg::CMD_ROW, rows[k]);
    end
    // an occasional missing finish merges two pairs into one
    if ($urandom_range(0, 99) < 95) begin
      send_item(kwod_pkg::CMD_FINISH, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic random_pairs(int unsigned count);
    int unsigned stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      send_pair();
    end
  endtask

  // short directed pairs covering the corner cases
  task automatic directed_pairs();
    // both strings empty
    send_item(kwod_pkg::CMD_FINISH, 8'hFF);
    // adjacent swap "ab" against "ba"
    send_item(kwod_pkg::CMD_APPEND, "a");
    send_item(kwod_pkg::CMD_APPEND, "b");
    send_item(kwod_pkg::CMD_ROW, "b");
    send_item(kwod_pkg::CMD_ROW, "a");
    send_item(kwod_pkg::CMD_FINISH, 8'h00);
    // case folding, high bytes, a late append and an unused command
    send_item(kwod_pkg::CMD_APPEND, "Q");
    send_item(kwod_pkg::CMD_APPEND, 8'h80);
    send_item(kwod_pkg::CMD_ROW, "q");
    send_item(kwod_pkg::CMD_APPEND, "z");
    send_item(CMD_NONE, 8'h55);
    send_item(kwod_pkg::CMD_ROW, 8'hFF);
    send_item(kwod_pkg::CMD_FINISH, 8'hAA);
    // keyboard costs at the far corners of the grid
    send_item(kwod_pkg::CMD_APPEND, "1");
    send_item(kwod_pkg::CMD_APPEND, "m");
    send_item(kwod_pkg::CMD_ROW, "p");
    send_item(kwod_pkg::CMD_ROW, "0");
    send_item(kwod_pkg::CMD_FINISH, 8'h00);
    // empty first string, then empty second string
    send_item(kwod_pkg::CMD_APPEND, "x");
    send_item(kwod_pkg::CMD_APPEND, "y");
    send_item(kwod_pkg::CMD_APPEND, "z");
    send_item(kwod_pkg::CMD_FINISH, 8'h00);
    send_item(kwod_pkg::CMD_ROW, "a");
    send_item(kwod_pkg::CMD_ROW, "b");
    send_item(kwod_pkg::CMD_FINISH, 8'h00);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_cmd <= kwod_pkg::CMD_APPEND;
    in_ch <= 8'h00;
    cfg_valid <= 1'b0;
    cfg_data <= 1'b0;
    hold_req = 1'b0;
    items_sent = 0;
    tx_idle_pct = 16;
    rx_idle_pct = 55;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // transposition enabled out of reset
    directed_pairs();
    drain();
    write_transpose(1'b0);
    random_pairs(300);
    drain();
    write_transpose(1'b1);
    random_pairs(350);

    // swap the idle rates of the two sides
    tx_idle_pct = 55;
    rx_idle_pct = 16;
    random_pairs(300);
    drain();
    write_transpose(1'b0);
    random_pairs(350);

    // no idling; hold the result side off while short pairs keep coming
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req = 1'b1;
    repeat (30) begin
      send_item(kwod_pkg::CMD_APPEND, pick_char());
      send_item(kwod_pkg::CMD_ROW, pick_char());
      send_item(kwod_pkg::CMD_FINISH, 8'($urandom_range(0, 255)));
    end
    drain();
    write_transpose(1'b1);
    random_pairs(300);
    drain();
    write_transpose(1'b0);
    random_pairs(300);

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS keyboard_weighted_osa_distance_top");
    end else begin
      $display("FAIL keyboard_weighted_osa_distance_top");
    end
    $finish;
  end

endmodule

### keyboard_weighted_osa_distance_top.f
sv/kwod_pkg.sv
sv/kwod_cell.sv
sv/keyboard_weighted_osa_distance_top.sv
sv/kwod_checker.sv
dv/tb.sv
